[hw/rtl/output_restricted_deque_top_macros.svh]
// Assertion macros for the deque top level.
`ifndef OUTPUT_RESTRICTED_DEQUE_TOP_MACROS_SVH
`define OUTPUT_RESTRICTED_DEQUE_TOP_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define ORQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("deque invariant violated");

// Consequent that must hold in the cycle after the antecedent.
`define ORQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deque sequence violated");

`endif

[hw/rtl/orq_pkg.sv]
package orq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP        = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      op;
        logic signed [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] popped;
        logic [CNT_W-1:0]         count;
    } t_out_item;

endpackage

[hw/rtl/output_restricted_deque_top.sv]
// Output-restricted deque over a circular single-port-read store.
// Push, unused or refused op: result strobe in the cycle after start, busy stays low.
// Pop: S_POP holds the registered store read, then the result; busy high for one cycle.
// Throughput: one push per cycle while not busy; a pop holds off the next op while busy.
// Synchronous active-low reset empties the deque; the receiver cannot stall results.
`include "output_restricted_deque_top_macros.svh"

module output_restricted_deque_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  orq_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_valid,
    output orq_pkg::t_out_item  o_result
);
    import orq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_held, n_held;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic               r_pop_sel, n_pop_sel;

    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [WORD_W-1:0]  r_rd_data;

    logic               accept;
    logic               full, empty;
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   back_addr, head_dec, head_inc;
    logic [CNT_W:0]     back_sum;

    assign accept = start && !busy;
    assign full   = (r_held == DEPTH_CNT);
    assign empty  = (r_held == '0);

    // Back slot: (head + held) wrapped once into the store.
    assign back_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, r_head} + {1'b0, r_held};
    assign back_addr = (back_sum >= {1'b0, DEPTH_CNT})
                     ? IDX_W'(back_sum - {1'b0, DEPTH_CNT})
                     : IDX_W'(back_sum);
    assign head_dec  = (r_head == '0) ? IDX_LAST : r_head - 1'b1;
    assign head_inc  = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_held    = r_held;
        n_valid   = 1'b0;
        n_status  = ST_DONE;
        n_pop_sel = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = back_addr;
        rd_en     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    unique case (i_item.op)
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en  = 1'b1;
                                n_held = r_held + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = head_dec;
                                n_head  = head_dec;
                                n_held  = r_held + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // hold the result until the store read returns
                                n_valid = 1'b0;
                                rd_en   = 1'b1;
                                n_head  = head_inc;
                                n_held  = r_held - 1'b1;
                                n_state = S_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_valid   = 1'b1;
                n_pop_sel = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_held    <= '0;
            r_valid   <= 1'b0;
            r_status  <= ST_DONE;
            r_pop_sel <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_held    <= n_held;
            r_valid   <= n_valid;
            r_status  <= n_status;
            r_pop_sel <= n_pop_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_item.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign busy             = (r_state == S_POP);
    assign o_valid          = r_valid;
    assign o_result.status  = r_status;
    assign o_result.popped  = r_pop_sel ? r_rd_data : '0;
    assign o_result.count   = r_held;

    `ORQ_ASSERT_ALWAYS(a_held_in_range, r_held <= DEPTH_CNT)
    `ORQ_ASSERT_NEXT(a_pop_waits, accept && i_item.op == OP_POP && !empty, busy && !o_valid)
    `ORQ_ASSERT_NEXT(a_busy_one_cycle, busy, o_valid && !busy && o_result.status == ST_DONE)
    `ORQ_ASSERT_NEXT(a_full_refused,
        accept && full && (i_item.op == OP_PUSH_BACK || i_item.op == OP_PUSH_FRONT),
        o_valid && o_result.status == ST_FULL && o_result.count == DEPTH_CNT)

endmodule

[bench/output_restricted_deque_top_tb.sv]
`timescale 1ns / 1ps

module output_restricted_deque_top_tb;

    import orq_pkg::*;

    localparam int          N_RANDOM       = 1800;
    localparam int          QUIET_TAIL     = 200;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    class deque_shadow;
        logic signed [WORD_W-1:0] words [DEPTH];
        int        head;
        int        held;
        t_out_item pending[$];
        int        errors;

        function new();
            head   = 0;
            held   = 0;
            errors = 0;
        endfunction

        // Advance the shadow deque by one accepted item and queue its result.
        function void apply_op(t_in_item it);
            t_out_item r;
            r.status = ST_DONE;
            r.popped = '0;
            case (it.op)
                OP_PUSH_BACK, OP_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else if (it.op == OP_PUSH_BACK) begin
                        words[(head + held) % DEPTH] = it.value;
                        held++;
                    end else begin
                        head        = (head + DEPTH - 1) % DEPTH;
                        words[head] = it.value;
                        held++;
                    end
                end
                OP_POP: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = words[head];
                        head     = (head + 1) % DEPTH;
                        held--;
                    end
                end
                default: ;
            endcase
            r.count = CNT_W'(held);
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $error("unexpected result: status %0d popped %0d count %0d",
                       got.status, got.popped, got.count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.popped !== want.popped) begin
                $error("popped: expected %0d, got %0d", want.popped, got.popped);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    t_in_item   i_item  = '0;
    logic       busy;
    logic       o_valid;
    t_out_item  o_result;

    deque_shadow shadow = new();
    int          quiet_cycles = 0;

    output_restricted_deque_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                shadow.check_result(o_result);
            if (start && !busy)
                shadow.apply_op(i_item);
        end
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hold the item on the inputs until the block takes it; leave start high.
    task automatic send(input t_op op, input logic signed [WORD_W-1:0] value);
        start        <= 1'b1;
        i_item.op    <= op;
        i_item.value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int  sent;
        int  seg_len;
        int  push_pct;
        int  roll;
        bit  idle_on;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pop from empty, fill with extreme words from both ends, then overflow.
        send(OP_POP, WORD_MAX);
        send(OP_PUSH_BACK, WORD_MAX);
        send(OP_PUSH_FRONT, WORD_MIN);
        send(OP_PUSH_BACK, -1);
        send(OP_PUSH_FRONT, '0);
        send(OP_PUSH_BACK, 32'sh5555_5555);
        send(OP_PUSH_FRONT, 32'shAAAA_AAAA);
        send(OP_PUSH_BACK, 1);
        send(OP_PUSH_FRONT, -2);
        send(OP_PUSH_BACK, 7);
        send(OP_PUSH_FRONT, 9);
        send(t_op'(OP_UNUSED), 123);
        repeat (DEPTH) send(OP_POP, $urandom);
        send(OP_POP, '0);
        send(t_op'(OP_UNUSED), -1);

        sent = 0;
        while (sent < N_RANDOM) begin
            seg_len = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            idle_on = ($urandom_range(2) != 0);
            for (int k = 0; k < seg_len && sent < N_RANDOM; k++) begin
                if (idle_on && (sent < N_RANDOM - QUIET_TAIL) && $urandom_range(4) == 0)
                    pause($urandom_range(1, 16));
                roll = $urandom_range(99);
                if (roll < 2) begin
                    send(t_op'(OP_UNUSED), pick_word());
                end else begin
                    if (roll < push_pct)
                        send($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
                    else
                        send(OP_POP, pick_word());
                    sent++;
                end
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then allow the pop pipeline to settle.
        while (shadow.pending.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (shadow.pending.size() != 0)
            $error("results: expected %0d more, got 0", shadow.pending.size());

        if (shadow.errors == 0 && shadow.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
